FILE: hdl/hpp_pkg.sv
// Shared types and constants for the heading pinhole point projection block.
// No dependencies; every other file imports this package.
package hpp_pkg;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [19:0] pixel_col;
    logic signed [19:0] pixel_row;
    logic               behind_camera;
  } result_t;

  typedef struct packed {
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [31:0] base_z;
    logic [12:0]        heading_angle;
    logic [19:0]        focal_x_pixels;
    logic [19:0]        focal_y_pixels;
    logic [15:0]        center_x_pixels;
    logic [15:0]        center_y_pixels;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [25:0] sin_q24;
    logic signed [25:0] cos_q24;
  } trig_t;

  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
  } delta_t;

  typedef enum logic [2:0] {
    TRIG_IDLE,
    TRIG_LOAD,
    TRIG_ARG,
    TRIG_SQ,
    TRIG_DIV,
    TRIG_MUL,
    TRIG_FIN,
    TRIG_APPLY
  } trig_state_t;

  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_X   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_Y   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_Z   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 4'd7;

  localparam logic [19:0] FOCAL_X_RESET  = 20'd62951;
  localparam logic [19:0] FOCAL_Y_RESET  = 20'd63297;
  localparam logic [15:0] CENTER_X_RESET = 16'd15360;
  localparam logic [15:0] CENTER_Y_RESET = 16'd8640;

  localparam logic [12:0] FULL_TURN    = 13'd5760;
  localparam logic [12:0] QUARTER_TURN = 13'd1440;
  localparam logic [31:0] ANGLE_STEP_Q40 = 32'd1199381129;

  localparam int NUM_W = 58;
  localparam int DEN_W = 37;
  localparam int QUO_W = 21;

  localparam logic signed [22:0] PIX_MAX = 23'sd524287;
  localparam logic signed [22:0] PIX_MIN = -23'sd524288;

  localparam int ACCEPT_TO_DONE = 31;

endpackage

FILE: hdl/hpp_trig.sv
// Sine/cosine sequencer: Taylor series on one shared multiplier, constant divides by reciprocal.
// Depends on hpp_pkg.
module hpp_trig (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  logic [12:0]    heading,
  output logic           busy,
  output hpp_pkg::trig_t trig
);
  import hpp_pkg::*;

  localparam logic [31:0] RECIP_55 = 32'd2498890064;
  localparam logic [31:0] RECIP_9  = 32'd954437177;
  localparam logic [31:0] RECIP_21 = 32'd3272356036;
  localparam logic [31:0] RECIP_5  = 32'd1717986919;
  localparam logic [31:0] RECIP_3  = 32'd2863311531;

  trig_state_t state, state_next;

  logic        phase;
  logic [1:0]  quad;
  logic [10:0] rem_r, arg;
  logic [30:0] x, t;
  logic [31:0] x2, dvd;
  logic [2:0]  k;
  logic [24:0] sr, cr;

  logic [12:0] hw;
  logic [1:0]  hq;
  logic [12:0] hr_full;
  logic [10:0] hr;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [42:0] arg_sum;
  logic [31:0] fin_sum;
  logic [24:0] sine_q24;
  logic [31:0] dvd_sh, recip;
  logic [31:0] q_fin;
  logic [32:0] tdiff;
  logic [30:0] t_nx;
  trig_t       trig_nx;

  always_comb begin
    hw = (heading >= FULL_TURN) ? heading - FULL_TURN : heading;
    if (hw >= 13'd4320) begin
      hq = 2'd3;
      hr_full = hw - 13'd4320;
    end else if (hw >= 13'd2880) begin
      hq = 2'd2;
      hr_full = hw - 13'd2880;
    end else if (hw >= QUARTER_TURN) begin
      hq = 2'd1;
      hr_full = hw - QUARTER_TURN;
    end else begin
      hq = 2'd0;
      hr_full = hw;
    end
    hr = hr_full[10:0];
  end

  always_comb begin
    unique case (k)
      3'd0: begin
        dvd_sh = {1'b0, dvd[31:1]};
        recip  = RECIP_55;
      end
      3'd1: begin
        dvd_sh = {3'd0, dvd[31:3]};
        recip  = RECIP_9;
      end
      3'd2: begin
        dvd_sh = {1'b0, dvd[31:1]};
        recip  = RECIP_21;
      end
      3'd3: begin
        dvd_sh = {2'd0, dvd[31:2]};
        recip  = RECIP_5;
      end
      default: begin
        dvd_sh = {1'b0, dvd[31:1]};
        recip  = RECIP_3;
      end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      TRIG_ARG: begin
        mul_a = {21'd0, arg};
        mul_b = ANGLE_STEP_Q40;
      end
      TRIG_SQ: begin
        mul_a = {1'b0, x};
        mul_b = {1'b0, x};
      end
      TRIG_DIV: begin
        mul_a = dvd_sh;
        mul_b = recip;
      end
      TRIG_MUL: begin
        mul_a = x2;
        mul_b = {1'b0, t};
      end
      TRIG_FIN: begin
        mul_a = {1'b0, x};
        mul_b = {1'b0, t};
      end
      default: ;
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign arg_sum  = {1'b0, prod[41:0]} + 43'd512;
  assign fin_sum  = {1'b0, prod[60:30]} + 32'd32;
  assign sine_q24 = fin_sum[30:6];

  always_comb begin
    unique case (k)
      3'd0:    q_fin = {5'd0, prod[63:37]};
      3'd2:    q_fin = {4'd0, prod[63:36]};
      default: q_fin = {1'b0, prod[63:33]};
    endcase
  end

  assign tdiff = 33'h040000000 - {1'b0, q_fin};
  assign t_nx  = tdiff[30:0];

  always_comb begin
    unique case (quad)
      2'd0: begin
        trig_nx.sin_q24 = $signed({1'b0, sr});
        trig_nx.cos_q24 = $signed({1'b0, cr});
      end
      2'd1: begin
        trig_nx.sin_q24 = $signed({1'b0, cr});
        trig_nx.cos_q24 = -$signed({1'b0, sr});
      end
      2'd2: begin
        trig_nx.sin_q24 = -$signed({1'b0, sr});
        trig_nx.cos_q24 = -$signed({1'b0, cr});
      end
      default: begin
        trig_nx.sin_q24 = -$signed({1'b0, cr});
        trig_nx.cos_q24 = $signed({1'b0, sr});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TRIG_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      TRIG_IDLE:  state_next = TRIG_IDLE;
      TRIG_LOAD:  state_next = TRIG_ARG;
      TRIG_ARG:   state_next = TRIG_SQ;
      TRIG_SQ:    state_next = TRIG_DIV;
      TRIG_DIV:   state_next = (k == 3'd4) ? TRIG_FIN : TRIG_MUL;
      TRIG_MUL:   state_next = TRIG_DIV;
      TRIG_FIN:   state_next = phase ? TRIG_APPLY : TRIG_ARG;
      TRIG_APPLY: state_next = TRIG_IDLE;
      default:    state_next = TRIG_IDLE;
    endcase
    if (go) begin
      state_next = TRIG_LOAD;
    end
  end

  assign busy = state != TRIG_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      k     <= '0;
      phase <= 1'b0;
    end else begin
      unique case (state)
        TRIG_LOAD: begin
          quad  <= hq;
          rem_r <= hr;
          arg   <= hr;
          phase <= 1'b0;
        end
        TRIG_ARG: x <= arg_sum[40:10];
        TRIG_SQ: begin
          x2  <= prod[61:30];
          dvd <= prod[61:30];
          k   <= '0;
        end
        TRIG_DIV: t <= t_nx;
        TRIG_MUL: begin
          dvd <= prod[61:30];
          k   <= k + 3'd1;
        end
        TRIG_FIN: begin
          if (!phase) begin
            sr    <= sine_q24;
            arg   <= QUARTER_TURN[10:0] - rem_r;
            phase <= 1'b1;
          end else begin
            cr <= sine_q24;
          end
        end
        TRIG_APPLY: trig <= trig_nx;
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/hpp_front.sv
// Front end: accepts points, subtracts the camera base and queues the differences.
// Depends on hpp_pkg.
module hpp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  hpp_pkg::point_t    point,
  input  hpp_pkg::cfg_regs_t cfg,
  input  logic               trig_busy,
  output logic               busy,
  output logic               head_valid,
  output hpp_pkg::delta_t    head
);
  import hpp_pkg::*;

  delta_t     q_mem [2];
  logic [1:0] count;
  logic       wr_ptr, rd_ptr;
  logic       push, pop;
  delta_t     delta_in;

  assign busy = trig_busy || (count == 2'd2);
  assign push = start && !busy;
  assign pop  = count != 2'd0;

  assign delta_in.dx = {point.point_x[31], point.point_x} - {cfg.base_x[31], cfg.base_x};
  assign delta_in.dy = {point.point_y[31], point.point_y} - {cfg.base_y[31], cfg.base_y};
  assign delta_in.dz = {point.point_z[31], point.point_z} - {cfg.base_z[31], cfg.base_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= delta_in;
    end
  end

  assign head_valid = pop;
  assign head       = q_mem[rd_ptr];

endmodule

FILE: hdl/hpp_div.sv
// Pipelined truncating divider with center add and saturation, one bit per stage.
// Depends on hpp_pkg.
module hpp_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [hpp_pkg::NUM_W-1:0] num,
  input  logic [hpp_pkg::DEN_W-1:0] den,
  input  logic                      neg,
  input  logic [15:0]               center,
  input  logic                      behind,
  output logic                      out_valid,
  output logic signed [19:0]        pix,
  output logic                      out_behind
);
  import hpp_pkg::*;

  localparam int NS = QUO_W + 1;

  logic [NS-1:0]    vld, ngs, bhs, ovs;
  logic [NUM_W-1:0] rem [NS];
  logic [DEN_W-1:0] dsr [NS];
  logic [QUO_W-1:0] quo [NS];
  logic [15:0]      ctr [NS];

  logic [NUM_W-1:0] trial [NS];
  logic [NS-1:0]    take;

  logic signed [21:0] qs;
  logic signed [22:0] sum;
  logic signed [22:0] sat;

  always_comb begin
    trial[0] = '0;
    take[0]  = 1'b0;
    for (int j = 1; j < NS; j++) begin
      trial[j] = {{(NUM_W-DEN_W){1'b0}}, dsr[j-1]} << (QUO_W - j);
      take[j]  = rem[j-1] >= trial[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      vld       <= {vld[NS-2:0], in_valid};
      out_valid <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= num;
    dsr[0] <= den;
    quo[0] <= '0;
    ngs[0] <= neg;
    bhs[0] <= behind;
    ctr[0] <= center;
    ovs[0] <= num >= {den, {QUO_W{1'b0}}};
    for (int j = 1; j < NS; j++) begin
      rem[j] <= take[j] ? rem[j-1] - trial[j] : rem[j-1];
      dsr[j] <= dsr[j-1];
      quo[j] <= quo[j-1] | (QUO_W'(take[j]) << (QUO_W - j));
      ngs[j] <= ngs[j-1];
      bhs[j] <= bhs[j-1];
      ctr[j] <= ctr[j-1];
      ovs[j] <= ovs[j-1];
    end
  end

  always_comb begin
    qs  = ngs[NS-1] ? -$signed({1'b0, quo[NS-1]}) : $signed({1'b0, quo[NS-1]});
    sum = 23'(qs) + $signed({7'd0, ctr[NS-1]});
    if (ovs[NS-1]) begin
      sat = ngs[NS-1] ? PIX_MIN : PIX_MAX;
    end else if (sum > PIX_MAX) begin
      sat = PIX_MAX;
    end else if (sum < PIX_MIN) begin
      sat = PIX_MIN;
    end else begin
      sat = sum;
    end
  end

  always_ff @(posedge clk) begin
    pix        <= bhs[NS-1] ? 20'sd0 : sat[19:0];
    out_behind <= bhs[NS-1];
  end

endmodule

FILE: hdl/hpp_back.sv
// Back end: rotation by heading, rounding, focal products and the two pixel dividers.
// Depends on hpp_pkg and hpp_div.
module hpp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  hpp_pkg::delta_t    delta,
  input  hpp_pkg::trig_t     trig,
  input  hpp_pkg::cfg_regs_t cfg,
  output logic               out_valid,
  output hpp_pkg::result_t   result
);
  import hpp_pkg::*;

  logic [6:0] v;

  logic signed [16:0] dxh, dxl, dyh, dyl;
  logic signed [42:0] cxh, cxl, syh, syl, sxh, sxl, cyh, cyl;
  logic signed [33:0] up0, up1, up2, up3;
  logic signed [59:0] lat1, dep1;
  logic               lneg, dneg;
  logic [59:0]        lmag, dmag, lrs, drs;
  logic signed [35:0] lat3, dep3, dep4, dep5;
  logic signed [38:0] pxh;
  logic signed [39:0] pxl;
  logic signed [37:0] pyh;
  logic signed [38:0] pyl;
  logic               beh4, beh5, beh6;
  logic signed [55:0] numx, numy;
  logic [55:0]        magx, magy;
  logic [NUM_W-1:0]   nx, ny;
  logic [DEN_W-1:0]   dd;
  logic               ngx, ngy;
  logic signed [20:0] fx, fy;
  logic signed [19:0] col, row;
  logic               beh_out;

  assign dxh = delta.dx[32:16];
  assign dxl = $signed({1'b0, delta.dx[15:0]});
  assign dyh = delta.dy[32:16];
  assign dyl = $signed({1'b0, delta.dy[15:0]});
  assign fx  = $signed({1'b0, cfg.focal_x_pixels});
  assign fy  = $signed({1'b0, cfg.focal_y_pixels});

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    cxh <= trig.cos_q24 * dxh;
    cxl <= trig.cos_q24 * dxl;
    syh <= trig.sin_q24 * dyh;
    syl <= trig.sin_q24 * dyl;
    sxh <= trig.sin_q24 * dxh;
    sxl <= trig.sin_q24 * dxl;
    cyh <= trig.cos_q24 * dyh;
    cyl <= trig.cos_q24 * dyl;
    up0 <= -$signed({delta.dz[32], delta.dz});

    lat1 <= (60'(cxh) <<< 16) + 60'(cxl) - (60'(syh) <<< 16) - 60'(syl);
    dep1 <= (60'(sxh) <<< 16) + 60'(sxl) + (60'(cyh) <<< 16) + 60'(cyl);
    up1  <= up0;

    lneg <= lat1[59];
    dneg <= dep1[59];
    lmag <= lat1[59] ? 60'(-lat1) : 60'(lat1);
    dmag <= dep1[59] ? 60'(-dep1) : 60'(dep1);
    up2  <= up1;

    lat3 <= lneg ? -$signed(lrs[59:24]) : $signed(lrs[59:24]);
    dep3 <= dneg ? -$signed(drs[59:24]) : $signed(drs[59:24]);
    up3  <= up2;

    pxh  <= fx * $signed(lat3[35:18]);
    pxl  <= fx * $signed({1'b0, lat3[17:0]});
    pyh  <= fy * $signed(up3[33:17]);
    pyl  <= fy * $signed({1'b0, up3[16:0]});
    dep4 <= dep3;
    beh4 <= dep3 <= 36'sd0;

    numx <= (56'(pxh) <<< 18) + 56'(pxl);
    numy <= (56'(pyh) <<< 17) + 56'(pyl);
    dep5 <= dep4;
    beh5 <= beh4;

    ngx  <= numx[55];
    ngy  <= numy[55];
    beh6 <= beh5;
    if (beh5) begin
      nx <= '0;
      ny <= '0;
      dd <= DEN_W'(2);
    end else begin
      nx <= {1'b0, magx, 1'b0} + {22'd0, dep5};
      ny <= {1'b0, magy, 1'b0} + {22'd0, dep5};
      dd <= {dep5, 1'b0};
    end
  end

  assign lrs  = lmag + 60'h000000000800000;
  assign drs  = dmag + 60'h000000000800000;
  assign magx = numx[55] ? 56'(-numx) : 56'(numx);
  assign magy = numy[55] ? 56'(-numy) : 56'(numy);

  hpp_div u_div_col (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v[6]),
    .num        (nx),
    .den        (dd),
    .neg        (ngx),
    .center     (cfg.center_x_pixels),
    .behind     (beh6),
    .out_valid  (out_valid),
    .pix        (col),
    .out_behind (beh_out)
  );

  hpp_div u_div_row (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v[6]),
    .num        (ny),
    .den        (dd),
    .neg        (ngy),
    .center     (cfg.center_y_pixels),
    .behind     (beh6),
    .out_valid  (),
    .pix        (row),
    .out_behind ()
  );

  assign result.pixel_col     = col;
  assign result.pixel_row     = row;
  assign result.behind_camera = beh_out;

endmodule

FILE: hdl/heading_pinhole_point_projection.sv
// Top level: configuration registers, trig sequencer, front queue and back pipeline.
// Depends on hpp_pkg, hpp_trig, hpp_front, hpp_back.
// Path: an accepted point is queued in the front end, passes the back pipeline
// (rotation, rounding, focal products, divider set-up) and the two dividers.
// Throughput: one point per cycle while busy is low; done cannot be held off.
// After reset and after each heading write the sine/cosine sequencer runs
// (one shared multiplier, reciprocal constant divides), holding busy high.
// Reset is synchronous, active high; registers return to their default camera.
module heading_pinhole_point_projection (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  hpp_pkg::point_t               point,
  output logic                          done,
  output hpp_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import hpp_pkg::*;

  cfg_regs_t cfg;
  trig_t     trig;
  delta_t    head;
  logic      trig_busy, head_valid, cfg_wr, go;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign go        = cfg_wr && (cfg_index == REG_HEADING);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_x          <= '0;
      cfg.base_y          <= '0;
      cfg.base_z          <= '0;
      cfg.heading_angle   <= '0;
      cfg.focal_x_pixels  <= FOCAL_X_RESET;
      cfg.focal_y_pixels  <= FOCAL_Y_RESET;
      cfg.center_x_pixels <= CENTER_X_RESET;
      cfg.center_y_pixels <= CENTER_Y_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_BASE_X:   cfg.base_x          <= $signed(cfg_data);
        REG_BASE_Y:   cfg.base_y          <= $signed(cfg_data);
        REG_BASE_Z:   cfg.base_z          <= $signed(cfg_data);
        REG_HEADING:  cfg.heading_angle   <= cfg_data[12:0];
        REG_FOCAL_X:  cfg.focal_x_pixels  <= cfg_data[19:0];
        REG_FOCAL_Y:  cfg.focal_y_pixels  <= cfg_data[19:0];
        REG_CENTER_X: cfg.center_x_pixels <= cfg_data[15:0];
        REG_CENTER_Y: cfg.center_y_pixels <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  hpp_trig u_trig (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .heading (cfg.heading_angle),
    .busy    (trig_busy),
    .trig    (trig)
  );

  hpp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .point      (point),
    .cfg        (cfg),
    .trig_busy  (trig_busy),
    .busy       (busy),
    .head_valid (head_valid),
    .head       (head)
  );

  hpp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (head_valid),
    .delta     (head),
    .trig      (trig),
    .cfg       (cfg),
    .out_valid (done),
    .result    (result)
  );

endmodule

FILE: hdl/hpp_checker.sv
// Port-level checker for heading_pinhole_point_projection, bound to the top level.
// Depends on hpp_pkg.
module hpp_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input hpp_pkg::result_t result
);
  import hpp_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##ACCEPT_TO_DONE done)
    else $error("accepted transaction gave no result in time");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, ACCEPT_TO_DONE))
    else $error("result without matching transaction");

  a_behind_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.behind_camera) |-> (result.pixel_col == 20'sd0 &&
                                        result.pixel_row == 20'sd0))
    else $error("pixels not zero behind camera");

endmodule

bind heading_pinhole_point_projection hpp_checker u_hpp_checker (.*);

FILE: test/tb_heading_pinhole_point_projection.sv
// Testbench for heading_pinhole_point_projection: directed table, then random points
// checked against an in-bench projection predictor. Depends on hpp_pkg and the RTL.
module tb_heading_pinhole_point_projection;
  import hpp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;
  localparam int SETTLE_CYCLES = ACCEPT_TO_DONE + 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic signed [19:0] PIX_HI = 20'sd524287;
  localparam logic signed [19:0] PIX_LO = 20'sh80000;
  localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] C_MIN = 32'sh8000_0000;

  typedef struct {
    point_t  pt;
    bit      typed;
    result_t res;
  } dir_row_t;

  logic clk, rst, start, busy, done, cfg_valid, cfg_ready;
  point_t point;
  result_t result;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  cfg_regs_t cam;
  result_t pixel_fifo[$];
  dir_row_t dir_tab[$];
  int errors, n_points, n_results, n_behind, n_sat, quiet_cycles;
  bit calm;

  heading_pinhole_point_projection dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point(point),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  function automatic longint quarter_sine(int unsigned r);
    longint unsigned x, x2, t;
    x = (longint'(r) * 64'd1199381129 + 64'd512) >> 10;
    x2 = (x * x) >> 30;
    t = (64'd1 << 30) - x2 / 110;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
    t = (x * t) >> 30;
    return longint'((t + 64'd32) >> 6);
  endfunction

  function automatic longint drop_q24(longint v);
    if (v >= 0) return (v + (64'sd1 <<< 23)) >>> 24;
    return -((-v + (64'sd1 <<< 23)) >>> 24);
  endfunction

  function automatic longint div_nearest(longint num, longint den);
    if (num >= 0) return (2 * num + den) / (2 * den);
    return -((2 * (-num) + den) / (2 * den));
  endfunction

  function automatic logic signed [19:0] clamp_pixel(longint v);
    if (v > 524287) return PIX_HI;
    if (v < -524288) return PIX_LO;
    return v[19:0];
  endfunction

  function automatic result_t project_point(point_t p);
    int unsigned h, quad, r;
    longint sr, cr, s, c, dx, dy, dz, lat, depth;
    result_t o;
    h = cam.heading_angle;
    if (h >= 5760) h -= 5760;
    quad = h / 1440;
    r = h % 1440;
    sr = quarter_sine(r);
    cr = quarter_sine(1440 - r);
    case (quad)
      0: begin s = sr; c = cr; end
      1: begin s = cr; c = -sr; end
      2: begin s = -sr; c = -cr; end
      default: begin s = -cr; c = sr; end
    endcase
    dx = longint'(p.point_x) - longint'(cam.base_x);
    dy = longint'(p.point_y) - longint'(cam.base_y);
    dz = longint'(p.point_z) - longint'(cam.base_z);
    lat = drop_q24(c * dx - s * dy);
    depth = drop_q24(s * dx + c * dy);
    o = '0;
    if (depth <= 0) begin
      o.behind_camera = 1'b1;
      return o;
    end
    o.pixel_col = clamp_pixel(div_nearest(longint'(cam.focal_x_pixels) * lat, depth)
                              + longint'(cam.center_x_pixels));
    o.pixel_row = clamp_pixel(div_nearest(longint'(cam.focal_y_pixels) * (-dz), depth)
                              + longint'(cam.center_y_pixels));
    return o;
  endfunction

  task automatic send_point(point_t p, bit typed, result_t res);
    if (!calm && $urandom_range(99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    point <= p;
    do @(posedge clk); while (busy);
    pixel_fifo.push_back(typed ? res : project_point(p));
    n_points++;
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BASE_X:   cam.base_x = val;
      REG_BASE_Y:   cam.base_y = val;
      REG_BASE_Z:   cam.base_z = val;
      REG_HEADING:  cam.heading_angle = val[12:0];
      REG_FOCAL_X:  cam.focal_x_pixels = val[19:0];
      REG_FOCAL_Y:  cam.focal_y_pixels = val[19:0];
      REG_CENTER_X: cam.center_x_pixels = val[15:0];
      REG_CENTER_Y: cam.center_y_pixels = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pixel_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] near_base(logic [31:0] b);
    int sh;
    logic [31:0] off;
    sh = $urandom_range(4, 30);
    off = $urandom() >> (31 - sh);
    return ($urandom_range(1) != 0) ? b + off : b - off;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      n_results++;
      if (pixel_fifo.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result);
        errors++;
      end else begin
        want = pixel_fifo.pop_front();
        if (result.behind_camera) n_behind++;
        if (result.pixel_col == PIX_HI || result.pixel_col == PIX_LO) n_sat++;
        if (result.pixel_col !== want.pixel_col)
          $display("%0t: pixel_col expected %0d actual %0d", $time,
                   want.pixel_col, result.pixel_col);
        if (result.pixel_row !== want.pixel_row)
          $display("%0t: pixel_row expected %0d actual %0d", $time,
                   want.pixel_row, result.pixel_row);
        if (result.behind_camera !== want.behind_camera)
          $display("%0t: behind_camera expected %0b actual %0b", $time,
                   want.behind_camera, result.behind_camera);
        if (result !== want) errors++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", pixel_fifo.size());
      $display("tb_heading_pinhole_point_projection NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    point_t p;
    result_t none;
    logic [31:0] hd;
    calm = 1'b0;
    none = '0;
    rst = 1'b1; start = 1'b0; point = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    cam = '{base_x: 0, base_y: 0, base_z: 0, heading_angle: 0,
            focal_x_pixels: FOCAL_X_RESET, focal_y_pixels: FOCAL_Y_RESET,
            center_x_pixels: CENTER_X_RESET, center_y_pixels: CENTER_Y_RESET};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    dir_tab.push_back(dir_row_t'{'{0, 256, 0}, 1, '{20'sd15360, 20'sd8640, 1'b0}});
    dir_tab.push_back(dir_row_t'{'{0, 0, 0}, 1, '{0, 0, 1'b1}});
    dir_tab.push_back(dir_row_t'{'{0, -256, 0}, 1, '{0, 0, 1'b1}});
    dir_tab.push_back(dir_row_t'{'{-1, -1, -1}, 1, '{0, 0, 1'b1}});
    dir_tab.push_back(dir_row_t'{'{C_MAX, 1, 0}, 1, '{PIX_HI, 20'sd8640, 1'b0}});
    dir_tab.push_back(dir_row_t'{'{C_MIN, 1, C_MIN}, 1, '{PIX_LO, PIX_HI, 1'b0}});
    dir_tab.push_back(dir_row_t'{'{0, C_MAX, 0}, 1, '{20'sd15360, 20'sd8640, 1'b0}});
    dir_tab.push_back(dir_row_t'{'{0, C_MIN, 0}, 1, '{0, 0, 1'b1}});
    dir_tab.push_back(dir_row_t'{'{256, 256, 256}, 0, none});
    dir_tab.push_back(dir_row_t'{'{-256, 512, -128}, 0, none});
    dir_tab.push_back(dir_row_t'{'{C_MAX, C_MAX, C_MAX}, 0, none});
    dir_tab.push_back(dir_row_t'{'{1000, 5000, -3000}, 0, none});
    dir_tab.push_back(dir_row_t'{'{12345, 100, 7}, 0, none});
    dir_tab.push_back(dir_row_t'{'{32'h5555_5555, 32'h2AAA_AAAA, 32'h5555_5555}, 0, none});
    dir_tab.push_back(dir_row_t'{'{32'hAAAA_AAAA, 32'h0000_FFFF, 32'hAAAA_AAAA}, 0, none});
    dir_tab.push_back(dir_row_t'{'{-77777, 3, 99999}, 0, none});
    foreach (dir_tab[i]) send_point(dir_tab[i].pt, dir_tab[i].typed, dir_tab[i].res);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: hd = 5759;
        1: hd = 8191;
        2: hd = QUARTER_TURN;
        3: hd = 2 * QUARTER_TURN;
        4: hd = 3 * QUARTER_TURN + 17;
        default: hd = $urandom_range(0, 8191);
      endcase
      cfg_write(REG_BASE_X, ph == 1 ? C_MIN : (ph == 0 ? 32'd0 : $urandom()));
      cfg_write(REG_BASE_Y, ph == 1 ? C_MAX : (ph == 0 ? 32'd0 : $urandom()));
      cfg_write(REG_BASE_Z, ph == 1 ? C_MIN : (ph == 0 ? 32'd0 : $urandom()));
      cfg_write(REG_HEADING, hd);
      cfg_write(REG_FOCAL_X,
                ph == 0 ? 32'hFFFFF : (ph == 1 ? 32'd0 : $urandom_range(0, 20'hFFFFF)));
      cfg_write(REG_FOCAL_Y,
                ph == 0 ? 32'hFFFFF : (ph == 1 ? 32'd0 : $urandom_range(0, 20'hFFFFF)));
      cfg_write(REG_CENTER_X,
                ph == 0 ? 32'd0 : (ph == 1 ? 32'hFFFF : $urandom_range(0, 16'hFFFF)));
      cfg_write(REG_CENTER_Y,
                ph == 0 ? 32'd0 : (ph == 1 ? 32'hFFFF : $urandom_range(0, 16'hFFFF)));
      if (ph == 2) cfg_write(REG_UNUSED, $urandom());
      cfg_valid <= 1'b0;
      calm = (ph == 3);
      repeat (155) begin
        if ($urandom_range(99) < 20) begin
          p = '{$urandom(), $urandom(), $urandom()};
        end else begin
          p = '{near_base(cam.base_x), near_base(cam.base_y), near_base(cam.base_z)};
        end
        send_point(p, 0, none);
      end
    end

    drain();
    $display("%0d points projected, %0d results checked (%0d behind camera, %0d saturated)",
             n_points, n_results, n_behind, n_sat);
    $display("six camera settings incl. register extremes and heading wrap");
    if (errors == 0 && pixel_fifo.size() == 0) begin
      $display("tb_heading_pinhole_point_projection OK");
    end else begin
      $display("tb_heading_pinhole_point_projection NOT OK");
    end
    $finish;
  end

endmodule
